@@ design/bac_pkg.sv @@
// Package for the binary arithmetic coder: transaction payload types,
// command kinds and configuration register constants.
// No dependencies.
package bac_pkg;

	localparam int AddrW = 2;
	localparam int DataW = 32;

	// Configuration register byte addresses
	localparam logic [AddrW-1:0] REG_DECODE_MODE = 2'd0;

	// Command kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_CODE  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        bit_in;
		logic [11:0] probability;
		logic [63:0] lookahead;
	} bac_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       decoded_bit;
		logic [3:0] bytes_consumed;
		logic       last;
	} bac_out_t;

endpackage

@@ design/bac_mul.sv @@
// Shared multiplier of the binary arithmetic coder: one 32-bit half of the
// range times the probability, product registered. Depends on nothing.
module bac_mul #(
	parameter int PROB_BITS = 12
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [31:0]               a,
	input  logic [PROB_BITS-1:0]      b,
	output logic [32+PROB_BITS-1:0]   prod_q
);

	localparam int ProdW = 32 + PROB_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= ProdW'(a) * ProdW'(b);
		end
	end

endmodule

@@ design/binary_arithmetic_coder.sv @@
// Binary arithmetic coder (carry-less, 64-bit low/high/code), top level.
// Uses bac_pkg for payload types and constants, bac_mul for the multiplier.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command transaction:
//   start, code one bit, or flush. Output channel out_valid/out_stall/out_data
//   carries the results; each command gives one or more results, the final
//   one marked by last. decode_mode is set over the APB port; the user must
//   write it only while idle, which the block itself does not enforce.
//   A code-bit command runs a sequencer around one shared 32 x PROB_BITS
//   multiplier: after the accept cycle it steps through range, high product,
//   low product, split sum, midpoint and interval update, then shifts out
//   0 to 8 bytes, plus a final result when it is not an emitted byte. Start,
//   unused kinds and a decode-mode flush give a single reply; an encode flush
//   gives the eight bytes of low. The block takes no new command until the
//   current one has written its last result; the output register lets the
//   next command start while that result waits. When the receiver stalls,
//   the sequencer holds at the next result until the output register frees up;
//   nothing is dropped. Reset clears low to zero, high to all ones, code to
//   zero, decode_mode to zero and empties the output register.
module binary_arithmetic_coder #(
	parameter int PROB_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  bac_pkg::bac_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output bac_pkg::bac_out_t          out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bac_pkg::AddrW-1:0]  paddr,
	input  logic [bac_pkg::DataW-1:0]  pwdata,
	output logic [bac_pkg::DataW-1:0]  prdata,
	output logic                       pready
);

	localparam int ProdW   = 32 + PROB_BITS;
	localparam int ExtW    = (PROB_BITS > 12) ? PROB_BITS : 12;
	localparam int HiShift = 32 - PROB_BITS;
	localparam logic [PROB_BITS-1:0] PMax = {PROB_BITS{1'b1}};

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RANGE  = 3'd1;
	localparam logic [2:0] S_MULHI  = 3'd2;
	localparam logic [2:0] S_MULLO  = 3'd3;
	localparam logic [2:0] S_SUM    = 3'd4;
	localparam logic [2:0] S_MID    = 3'd5;
	localparam logic [2:0] S_UPDATE = 3'd6;
	localparam logic [2:0] S_SHIFT  = 3'd7;

	// flush and single replies use separate flags on top of the state code
	logic [2:0]            state_q;
	logic                  flush_q;
	logic                  reply_q;
	logic                  decode_mode_q;
	logic [63:0]           range_low_q;
	logic [63:0]           range_high_q;
	logic [63:0]           code_q;
	logic [63:0]           ahead_q;
	logic [63:0]           range_q;
	logic [63:0]           split_q;
	logic [63:0]           mid_q;
	logic [ProdW-1:0]      hi_q;
	logic [PROB_BITS-1:0]  prob_q;
	logic                  bit_q;
	logic [3:0]            n_q;
	logic                  out_valid_q;
	bac_pkg::bac_out_t     out_q;
	bac_pkg::bac_out_t     reply_data_q;

	logic                  cfg_write;
	logic                  in_accept;
	logic                  slot_free;
	logic                  out_load;
	logic [ExtW-1:0]       prob_ext;
	logic [PROB_BITS-1:0]  prob_sat;
	logic [31:0]           mul_a;
	logic                  mul_en;
	logic [ProdW-1:0]      prod;
	logic                  agree;
	logic                  more;
	logic                  last_emit;
	logic                  new_bit;

	// APB register
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign prdata    = {{(bac_pkg::DataW-1){1'b0}}, decode_mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (cfg_write && (paddr == bac_pkg::REG_DECODE_MODE)) begin
			decode_mode_q <= pwdata[0];
		end
	end

	assign in_stall   = (state_q != S_IDLE) || flush_q || reply_q;
	assign in_accept  = in_valid && !in_stall;
	assign slot_free  = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// load the output register with a reply, a flush byte or a code-step result
	assign out_load = slot_free && (((state_q == S_IDLE) && (reply_q || flush_q))
		|| ((state_q == S_SHIFT) && !(more && decode_mode_q)));

	// saturate the probability to the fraction width
	assign prob_ext = ExtW'(in_data.probability);
	assign prob_sat = (prob_ext > ExtW'(PMax)) ? PMax : PROB_BITS'(prob_ext);

	assign mul_en = (state_q == S_MULHI) || (state_q == S_MULLO);
	assign mul_a  = (state_q == S_MULHI) ? range_q[63:32] : range_q[31:0];

	bac_mul #(
		.PROB_BITS (PROB_BITS)
	) u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (prob_q),
		.prod_q (prod)
	);

	// the next top byte after a shift is bits 55:48 of the current low and high
	assign agree     = (range_low_q[63:56] == range_high_q[63:56]);
	assign more      = agree && (n_q != 4'd8);
	assign last_emit = (n_q == 4'd7) || (range_low_q[55:48] != range_high_q[55:48]);
	assign new_bit   = decode_mode_q ? (code_q <= mid_q) : bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			flush_q      <= 1'b0;
			reply_q      <= 1'b0;
			range_low_q  <= '0;
			range_high_q <= '1;
			code_q       <= '0;
			n_q          <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (reply_q) begin
						if (slot_free) begin
							out_q       <= reply_data_q;
							reply_q     <= 1'b0;
						end
					end else if (flush_q) begin
						if (slot_free) begin
							out_q       <= '{out_byte: range_low_q[63:56], byte_valid: 1'b1,
								decoded_bit: 1'b0, bytes_consumed: 4'd0,
								last: (n_q[2:0] == 3'd7)};
							range_low_q <= {range_low_q[55:0], 8'h00};
							n_q         <= n_q + 4'd1;
							if (n_q[2:0] == 3'd7) begin
								flush_q <= 1'b0;
							end
						end
					end else if (in_accept) begin
						reply_data_q <= '{out_byte: 8'd0, byte_valid: 1'b0, decoded_bit: 1'b0,
							bytes_consumed: ((in_data.kind == bac_pkg::KIND_START)
								&& decode_mode_q) ? 4'd8 : 4'd0,
							last: 1'b1};
						n_q <= '0;
						case (in_data.kind)
							bac_pkg::KIND_START: begin
								range_low_q  <= '0;
								range_high_q <= '1;
								if (decode_mode_q) begin
									code_q <= in_data.lookahead;
								end
								reply_q <= 1'b1;
							end
							bac_pkg::KIND_CODE: begin
								prob_q  <= prob_sat;
								bit_q   <= in_data.bit_in;
								ahead_q <= in_data.lookahead;
								state_q <= S_RANGE;
							end
							bac_pkg::KIND_FLUSH: begin
								if (decode_mode_q) begin
									reply_q <= 1'b1;
								end else begin
									flush_q <= 1'b1;
								end
							end
							default: begin
								reply_q <= 1'b1;
							end
						endcase
					end
				end
				S_RANGE: begin
					range_q <= range_high_q - range_low_q;
					state_q <= S_MULHI;
				end
				S_MULHI: begin
					state_q <= S_MULLO;
				end
				S_MULLO: begin
					hi_q    <= prod;
					state_q <= S_SUM;
				end
				S_SUM: begin
					split_q <= (64'(hi_q) << HiShift) + 64'(prod >> PROB_BITS);
					state_q <= S_MID;
				end
				S_MID: begin
					mid_q   <= range_low_q + split_q;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					bit_q <= new_bit;
					if (new_bit) begin
						range_high_q <= mid_q;
					end else begin
						range_low_q <= mid_q + 64'd1;
					end
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (more) begin
						if (decode_mode_q) begin
							code_q       <= {code_q[55:0], ahead_q[63:56]};
							ahead_q      <= {ahead_q[55:0], 8'h00};
							range_low_q  <= {range_low_q[55:0], 8'h00};
							range_high_q <= {range_high_q[55:0], 8'hFF};
							n_q          <= n_q + 4'd1;
						end else if (slot_free) begin
							out_q        <= '{out_byte: range_low_q[63:56], byte_valid: 1'b1,
								decoded_bit: 1'b0, bytes_consumed: 4'd0, last: last_emit};
							range_low_q  <= {range_low_q[55:0], 8'h00};
							range_high_q <= {range_high_q[55:0], 8'hFF};
							n_q          <= n_q + 4'd1;
							if (last_emit) begin
								state_q <= S_IDLE;
							end
						end
					end else if (slot_free) begin
						// decode reports bit and byte count; encode with no byte gives a blank
						out_q       <= '{out_byte: 8'd0, byte_valid: 1'b0,
							decoded_bit: decode_mode_q & bit_q,
							bytes_consumed: decode_mode_q ? n_q : 4'd0, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_low_not_above_high: assert property (@(posedge clk) disable iff (!arst_n)
		!flush_q |-> (range_low_q <= range_high_q))
		else $error("interval low above high");

	a_split_below_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID) |-> (split_q < range_q || range_q == 64'd0))
		else $error("split not below range");

	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (n_q <= 4'd8))
		else $error("more than eight bytes shifted");

	a_shift_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |=> (state_q == S_SHIFT && n_q == 4'd0))
		else $error("byte count not cleared at shift start");
`endif

endmodule
